[hdl/lmft_pkg.sv]
package lmft_pkg;

  // Table size and queue depths
  localparam int MAX_LINKS = 8;
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [15:0] MIN_FRAME_LEN = 16'd14;
  localparam int          GROUP_BIT     = 40;

  // Operation codes on the input channel
  localparam logic [1:0] OP_CONNECT    = 2'd0;
  localparam logic [1:0] OP_DISCONNECT = 2'd1;
  localparam logic [1:0] OP_LEARN      = 2'd2;
  localparam logic [1:0] OP_TRANSMIT   = 2'd3;

  // Command kinds after classification
  localparam logic [2:0] K_CONNECT    = 3'd0;
  localparam logic [2:0] K_DISCONNECT = 3'd1;
  localparam logic [2:0] K_LEARN      = 3'd2;
  localparam logic [2:0] K_TX_SHORT   = 3'd3;
  localparam logic [2:0] K_TX_GROUP   = 3'd4;
  localparam logic [2:0] K_TX_UNICAST = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NO_LINKS  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [47:0] mac;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        send_valid;
    logic [15:0] handle;
    logic [3:0]  link_count;
    logic        last_result;
  } res_t;

endpackage

[hdl/link_mac_forwarding_table.sv]
// Link MAC forwarding table: ordered list of up to MAX_LINKS (handle, MAC) entries.
// Input channel: drive a word on in_* with push high; it is taken on a clock edge
// where full is low. Operations: connect, disconnect, learn source, route transmit.
// Result channel: while empty is low the oldest result sits on out_*; pop high takes
// it. Each input gives one result, except a group transmit to a non-empty table,
// which gives a send result per entry in table order; last_result marks the last.
// Flow: a front classifier feeds a two-deep command queue; the engine then walks
// the table one entry per cycle, holding at an entry whose result meets a full result
// queue. It takes the next command only after the last result of the current one.
// A word passes through the command queue, the engine's command register and the
// result queue before its first result shows on out_*.
// A two-deep result queue lets the engine finish while the receiver holds pop low;
// when it fills, the engine stalls, then the command queue fills and full rises.
// Reset (rst_n low, synchronous) empties both queues and the table.
module link_mac_forwarding_table #(
  parameter int MAX_LINKS = lmft_pkg::MAX_LINKS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_link_handle,
  input  logic [47:0] in_mac_address,
  input  logic [15:0] in_frame_length,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic        out_send_valid,
  output logic [15:0] out_send_handle,
  output logic [3:0]  out_link_count,
  output logic        out_last_result
);

  lmft_pkg::cmd_t cmd;
  logic           cmd_empty, cmd_pop;
  lmft_pkg::res_t res_in, res_out;
  logic           res_push, res_full;
  logic [$bits(lmft_pkg::res_t)-1:0] res_bits;

  // Classify and queue commands
  lmft_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .operation    (in_operation),
    .link_handle  (in_link_handle),
    .mac_address  (in_mac_address),
    .frame_length (in_frame_length),
    .cmd_o        (cmd),
    .cmd_empty_o  (cmd_empty),
    .cmd_pop_i    (cmd_pop)
  );

  // Walk and update the table
  lmft_engine #(
    .MAX_LINKS (MAX_LINKS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Hold results for the receiver
  lmft_fifo #(
    .WIDTH ($bits(lmft_pkg::res_t)),
    .DEPTH (lmft_pkg::RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en_i   (res_push),
    .wr_data_i (res_in),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (res_bits),
    .empty_o   (empty)
  );

  assign res_out         = lmft_pkg::res_t'(res_bits);
  assign out_status      = res_out.status;
  assign out_send_valid  = res_out.send_valid;
  assign out_send_handle = res_out.handle;
  assign out_link_count  = res_out.link_count;
  assign out_last_result = res_out.last_result;

`ifndef NO_ASSERTIONS
  a_res_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result word pushed into a full queue");

  a_cmd_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

  a_send_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_send_valid) |-> (out_status == lmft_pkg::ST_OK))
    else $error("send result with a non-ok status");

  a_only_sends_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last_result) |-> out_send_valid)
    else $error("non-final result that is not a send");
`endif

endmodule

[hdl/lmft_fifo.sv]
module lmft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic             do_wr, do_rd;

  assign full_o    = (fill_r == FW'(DEPTH));
  assign empty_o   = (fill_r == '0);
  assign rd_data_o = mem_r[rd_ptr_r];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      fill_nxt = fill_r + FW'(1);
    end else if (do_rd && !do_wr) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data_i;
    end
  end

endmodule

[hdl/lmft_front.sv]
module lmft_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation,
  input  logic [15:0]        link_handle,
  input  logic [47:0]        mac_address,
  input  logic [15:0]        frame_length,
  output lmft_pkg::cmd_t     cmd_o,
  output logic               cmd_empty_o,
  input  logic               cmd_pop_i
);

  lmft_pkg::cmd_t cmd_in;
  logic [$bits(lmft_pkg::cmd_t)-1:0] cmd_bits;

  // Classify the word; for a transmit the short-frame check comes before the group check
  always_comb begin
    cmd_in.handle = link_handle;
    cmd_in.mac    = mac_address;
    case (operation)
      lmft_pkg::OP_CONNECT:    cmd_in.kind = lmft_pkg::K_CONNECT;
      lmft_pkg::OP_DISCONNECT: cmd_in.kind = lmft_pkg::K_DISCONNECT;
      lmft_pkg::OP_LEARN:      cmd_in.kind = lmft_pkg::K_LEARN;
      default: begin
        if (frame_length < lmft_pkg::MIN_FRAME_LEN) begin
          cmd_in.kind = lmft_pkg::K_TX_SHORT;
        end else if (mac_address[lmft_pkg::GROUP_BIT]) begin
          cmd_in.kind = lmft_pkg::K_TX_GROUP;
        end else begin
          cmd_in.kind = lmft_pkg::K_TX_UNICAST;
        end
      end
    endcase
  end

  // Queue classified commands toward the engine
  lmft_fifo #(
    .WIDTH ($bits(lmft_pkg::cmd_t)),
    .DEPTH (lmft_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en_i   (push),
    .wr_data_i (cmd_in),
    .full_o    (full),
    .rd_en_i   (cmd_pop_i),
    .rd_data_o (cmd_bits),
    .empty_o   (cmd_empty_o)
  );

  assign cmd_o = lmft_pkg::cmd_t'(cmd_bits);

endmodule

[hdl/lmft_engine.sv]
module lmft_engine #(
  parameter int MAX_LINKS = lmft_pkg::MAX_LINKS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lmft_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output lmft_pkg::res_t res_o
);

  localparam int CW = $clog2(MAX_LINKS + 1);
  localparam int IW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic           state_r, state_nxt;
  lmft_pkg::cmd_t cmd_r, cmd_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [15:0]    hdl_r [MAX_LINKS];
  logic [47:0]    mac_r [MAX_LINKS];

  logic           at_end, last_idx, no_links, tbl_full;
  logic [IW-1:0]  rd_idx;
  logic [15:0]    rd_hdl;
  logic [47:0]    rd_mac;
  logic           hit_h, hit_m;
  logic           decide, go;
  logic           append_en, shift_en, mac_wr_en;

  // Walk pointer and current entry
  assign at_end   = (idx_r == cnt_r);
  assign last_idx = (idx_r == cnt_r - CW'(1));
  assign no_links = (cnt_r == '0);
  assign tbl_full = (cnt_r == CW'(MAX_LINKS));
  assign rd_idx   = at_end ? '0 : idx_r[IW-1:0];
  assign rd_hdl   = hdl_r[rd_idx];
  assign rd_mac   = mac_r[rd_idx];
  assign hit_h    = !at_end && (rd_hdl == cmd_r.handle);
  assign hit_m    = !at_end && (rd_mac == cmd_r.mac);

  // Decide the result for the entry under the pointer
  always_comb begin
    decide            = 1'b0;
    append_en         = 1'b0;
    shift_en          = 1'b0;
    mac_wr_en         = 1'b0;
    res_o.status      = lmft_pkg::ST_OK;
    res_o.send_valid  = 1'b0;
    res_o.handle      = '0;
    res_o.link_count  = 4'(cnt_r);
    res_o.last_result = 1'b1;
    case (cmd_r.kind)
      lmft_pkg::K_CONNECT: begin
        decide    = hit_h || at_end;
        mac_wr_en = hit_h;
        if (!hit_h && tbl_full) begin
          res_o.status = lmft_pkg::ST_FULL;
        end else if (!hit_h) begin
          append_en        = 1'b1;
          res_o.link_count = 4'(cnt_r + CW'(1));
        end
      end
      lmft_pkg::K_DISCONNECT: begin
        decide   = hit_h || at_end;
        shift_en = hit_h;
        if (hit_h) begin
          res_o.link_count = 4'(cnt_r - CW'(1));
        end
      end
      lmft_pkg::K_LEARN: begin
        decide    = hit_h || at_end;
        mac_wr_en = hit_h;
      end
      lmft_pkg::K_TX_SHORT: begin
        decide       = 1'b1;
        res_o.status = lmft_pkg::ST_SHORT;
      end
      lmft_pkg::K_TX_GROUP: begin
        decide = 1'b1;
        if (no_links) begin
          res_o.status = lmft_pkg::ST_NO_LINKS;
        end else begin
          res_o.send_valid  = 1'b1;
          res_o.handle      = rd_hdl;
          res_o.last_result = last_idx;
        end
      end
      lmft_pkg::K_TX_UNICAST: begin
        if (no_links) begin
          decide       = 1'b1;
          res_o.status = lmft_pkg::ST_NO_LINKS;
        end else begin
          decide = hit_m || at_end;
          if (hit_m) begin
            res_o.send_valid = 1'b1;
            res_o.handle     = rd_hdl;
          end else if (cnt_r == CW'(1)) begin
            res_o.send_valid = 1'b1;
            res_o.handle     = hdl_r[0];
          end else begin
            res_o.status = lmft_pkg::ST_NOT_FOUND;
          end
        end
      end
      default: begin
        decide = 1'b1;
      end
    endcase
  end

  assign go         = (state_r == S_SCAN) && decide && !res_full_i;
  assign res_push_o = go;
  assign cmd_pop_o  = (state_r == S_IDLE) && !cmd_empty_i;

  // Track table fill
  always_comb begin
    cnt_nxt = cnt_r;
    if (go && append_en) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (go && shift_en) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // Sequence: take a command, walk entries, emit
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_pop_o) begin
          cmd_nxt   = cmd_i;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (go) begin
          if (res_o.last_result) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end else if (!decide) begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  // Table entries: close the gap on disconnect, append, or replace the MAC
  for (genvar i = 0; i < MAX_LINKS; i++) begin : g_entry
    logic [15:0] up_hdl;
    logic [47:0] up_mac;

    if (i < MAX_LINKS - 1) begin : g_up
      assign up_hdl = hdl_r[i+1];
      assign up_mac = mac_r[i+1];
    end else begin : g_top
      assign up_hdl = hdl_r[i];
      assign up_mac = mac_r[i];
    end

    always_ff @(posedge clk) begin
      if (go && shift_en && (IW'(i) >= rd_idx)) begin
        hdl_r[i] <= up_hdl;
        mac_r[i] <= up_mac;
      end else if (go && append_en && (cnt_r[IW-1:0] == IW'(i))) begin
        hdl_r[i] <= cmd_r.handle;
        mac_r[i] <= cmd_r.mac;
      end else if (go && mac_wr_en && (rd_idx == IW'(i))) begin
        mac_r[i] <= cmd_r.mac;
      end
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int DRAIN_CYCLES = 2 * lmft_pkg::MAX_LINKS + 8;

  // Directed table contents, entry 0 in the low slice
  localparam logic [7:0][15:0] FILL_HANDLES = {
    16'h7FFF, 16'hAAAA, 16'h5555, 16'h1234, 16'h8000, 16'h0001, 16'hFFFF, 16'h0000
  };
  localparam logic [7:0][47:0] FILL_MACS = {
    48'h7E_DC_BA_98_76_54, 48'h3C_00_00_00_00_0C, 48'h02_AA_BB_CC_DD_EE,
    48'h40_11_11_11_11_11, 48'h80_00_00_00_00_00, 48'h02_11_22_33_44_55,
    48'hFF_FF_FF_FF_FF_FF, 48'h00_00_00_00_00_00
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_operation = lmft_pkg::OP_CONNECT;
  logic [15:0] in_link_handle = '0;
  logic [47:0] in_mac_address = '0;
  logic [15:0] in_frame_length = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_status;
  logic        out_send_valid;
  logic [15:0] out_send_handle;
  logic [3:0]  out_link_count;
  logic        out_last_result;

  // Mirror of the forwarding table
  logic [15:0] link_handles [lmft_pkg::MAX_LINKS];
  logic [47:0] link_macs [lmft_pkg::MAX_LINKS];
  int          link_total = 0;

  // Result words still owed by the block, oldest first
  lmft_pkg::res_t fwd_results [$];

  // Shared values for random traffic, so handles and addresses repeat
  logic [15:0] handle_pool [12];
  logic [47:0] mac_pool [6];

  int          send_idle_pct = 29;
  int          recv_idle_pct = 55;
  int          error_count = 0;

  link_mac_forwarding_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_operation    (in_operation),
    .in_link_handle  (in_link_handle),
    .in_mac_address  (in_mac_address),
    .in_frame_length (in_frame_length),
    .empty           (empty),
    .pop             (pop),
    .out_status      (out_status),
    .out_send_valid  (out_send_valid),
    .out_send_handle (out_send_handle),
    .out_link_count  (out_link_count),
    .out_last_result (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_result(input logic [2:0] status, input logic send,
                              input logic [15:0] hdl, input logic last);
    lmft_pkg::res_t word;
    word.status      = status;
    word.send_valid  = send;
    word.handle      = hdl;
    word.link_count  = link_total[3:0];
    word.last_result = last;
    fwd_results.push_back(word);
  endtask

  // Apply one accepted word to the mirror table and queue the words it causes
  task automatic forward_step(input logic [1:0] op, input logic [15:0] hdl,
                              input logic [47:0] mac, input logic [15:0] len);
    int idx;
    idx = -1;
    for (int i = link_total - 1; i >= 0; i--)
      if (link_handles[i] == hdl) idx = i;

    if (op == lmft_pkg::OP_CONNECT) begin
      if (idx >= 0) begin
        link_macs[idx] = mac;
        queue_result(lmft_pkg::ST_OK, 1'b0, 16'h0, 1'b1);
      end else if (link_total >= lmft_pkg::MAX_LINKS) begin
        queue_result(lmft_pkg::ST_FULL, 1'b0, 16'h0, 1'b1);
      end else begin
        link_handles[link_total] = hdl;
        link_macs[link_total]    = mac;
        link_total++;
        queue_result(lmft_pkg::ST_OK, 1'b0, 16'h0, 1'b1);
      end
    end else if (op == lmft_pkg::OP_DISCONNECT) begin
      // Close the gap, keeping the order of the rest
      if (idx >= 0) begin
        for (int i = idx; i < link_total - 1; i++) begin
          link_handles[i] = link_handles[i + 1];
          link_macs[i]    = link_macs[i + 1];
        end
        link_total--;
      end
      queue_result(lmft_pkg::ST_OK, 1'b0, 16'h0, 1'b1);
    end else if (op == lmft_pkg::OP_LEARN) begin
      if (idx >= 0) link_macs[idx] = mac;
      queue_result(lmft_pkg::ST_OK, 1'b0, 16'h0, 1'b1);
    end else if (len < lmft_pkg::MIN_FRAME_LEN) begin
      queue_result(lmft_pkg::ST_SHORT, 1'b0, 16'h0, 1'b1);
    end else if (link_total == 0) begin
      queue_result(lmft_pkg::ST_NO_LINKS, 1'b0, 16'h0, 1'b1);
    end else if (mac[lmft_pkg::GROUP_BIT]) begin
      // Fan out over every link in table order
      for (int i = 0; i < link_total; i++)
        queue_result(lmft_pkg::ST_OK, 1'b1, link_handles[i], i == link_total - 1);
    end else begin
      idx = -1;
      for (int i = link_total - 1; i >= 0; i--)
        if (link_macs[i] == mac) idx = i;
      if (idx >= 0)
        queue_result(lmft_pkg::ST_OK, 1'b1, link_handles[idx], 1'b1);
      else if (link_total == 1)
        queue_result(lmft_pkg::ST_OK, 1'b1, link_handles[0], 1'b1);
      else
        queue_result(lmft_pkg::ST_NOT_FOUND, 1'b0, 16'h0, 1'b1);
    end
  endtask

  // Offer one word, hold it until the block takes it, then predict
  task automatic send_word(input logic [1:0] op, input logic [15:0] hdl,
                           input logic [47:0] mac, input logic [15:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_operation    <= op;
    in_link_handle  <= hdl;
    in_mac_address  <= mac;
    in_frame_length <= len;
    @(posedge clk);
    while (full) @(posedge clk);
    forward_step(op, hdl, mac, len);
  endtask

  // Empty table: error ordering, single-link fallback, unknown handles
  task automatic test_no_links();
    send_word(lmft_pkg::OP_TRANSMIT, 16'h0000, 48'h00_00_00_00_00_00, 16'd0);
    send_word(lmft_pkg::OP_TRANSMIT, 16'h0000, 48'h02_00_00_00_00_01, 16'd14);
    send_word(lmft_pkg::OP_CONNECT, 16'h00FF, 48'h02_12_34_56_78_9A, 16'd0);
    send_word(lmft_pkg::OP_TRANSMIT, 16'h0000, 48'h02_99_88_77_66_55, 16'hFFFF);
    send_word(lmft_pkg::OP_LEARN, 16'h0F0F, 48'h02_00_00_00_00_02, 16'd0);
    send_word(lmft_pkg::OP_DISCONNECT, 16'h00FF, 48'h0, 16'd0);
    send_word(lmft_pkg::OP_DISCONNECT, 16'h00FF, 48'h0, 16'd0);
  endtask

  // Fill every slot, overflow, then update a known handle on a full table
  task automatic test_fill_table();
    for (int i = 0; i < lmft_pkg::MAX_LINKS; i++)
      send_word(lmft_pkg::OP_CONNECT, FILL_HANDLES[i], FILL_MACS[i], 16'd0);
    send_word(lmft_pkg::OP_CONNECT, 16'h4321, 48'h02_43_21_43_21_43, 16'd0);
    send_word(lmft_pkg::OP_CONNECT, 16'h1234, 48'h0A_0B_0C_0D_0E_0F, 16'd0);
  endtask

  // Group fan-out, first-match unicast, miss, short frame
  task automatic test_routing();
    send_word(lmft_pkg::OP_TRANSMIT, 16'h0000, 48'h01_00_5E_00_00_01, 16'd14);
    send_word(lmft_pkg::OP_LEARN, 16'h5555, FILL_MACS[2], 16'd0);
    send_word(lmft_pkg::OP_TRANSMIT, 16'h0000, FILL_MACS[2], 16'd1500);
    send_word(lmft_pkg::OP_TRANSMIT, 16'h0000, 48'h00_12_34_56_78_9A, 16'd64);
    send_word(lmft_pkg::OP_TRANSMIT, 16'h0000, 48'hFF_FF_FF_FF_FF_FF, 16'd13);
  endtask

  // Remove first, middle and last entries, then check the order kept
  task automatic test_unlink();
    send_word(lmft_pkg::OP_DISCONNECT, 16'h0000, 48'h0, 16'd0);
    send_word(lmft_pkg::OP_DISCONNECT, 16'h1234, 48'h0, 16'd0);
    send_word(lmft_pkg::OP_DISCONNECT, 16'h7FFF, 48'h0, 16'd0);
    send_word(lmft_pkg::OP_TRANSMIT, 16'hFFFF, 48'hFF_FF_FF_FF_FF_FF, 16'd60);
  endtask

  // Mixed traffic over a small handle and address pool
  task automatic test_random_traffic(input int count);
    logic [1:0]  op;
    logic [15:0] hdl;
    logic [47:0] mac;
    logic [15:0] len;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 30)      op = lmft_pkg::OP_CONNECT;
      else if (pick < 55) op = lmft_pkg::OP_DISCONNECT;
      else if (pick < 70) op = lmft_pkg::OP_LEARN;
      else                op = lmft_pkg::OP_TRANSMIT;

      if ($urandom_range(9) == 0) hdl = 16'($urandom);
      else                        hdl = handle_pool[$urandom_range(11)];

      pick = $urandom_range(99);
      mac  = 48'({$urandom, $urandom});
      if (op == lmft_pkg::OP_TRANSMIT && pick < 40) mac[lmft_pkg::GROUP_BIT] = 1'b1;
      else if (pick < 80)                           mac = mac_pool[$urandom_range(5)];

      if ($urandom_range(99) < 15) len = 16'($urandom_range(13));
      else                         len = 16'($urandom_range(65535, 14));

      send_word(op, hdl, mac, len);
    end
  endtask

  // Take result words and compare each with the oldest prediction
  always @(posedge clk) begin : check_results
    lmft_pkg::res_t want;
    if (pop && !empty) begin
      if (fwd_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word status=%0d send=%0b handle=%h",
                                  out_status, out_send_valid, out_send_handle));
      end else begin
        want = fwd_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_send_valid !== want.send_valid)
          report_mismatch($sformatf("send_valid %0b, want %0b",
                                    out_send_valid, want.send_valid));
        if (out_send_handle !== want.handle)
          report_mismatch($sformatf("handle %h, want %h", out_send_handle, want.handle));
        if (out_link_count !== want.link_count)
          report_mismatch($sformatf("link_count %0d, want %0d",
                                    out_link_count, want.link_count));
        if (out_last_result !== want.last_result)
          report_mismatch($sformatf("last_result %0b, want %0b",
                                    out_last_result, want.last_result));
      end
    end
    pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    for (int i = 0; i < 12; i++) handle_pool[i] = 16'($urandom);
    for (int i = 0; i < 6; i++) begin
      mac_pool[i] = 48'({$urandom, $urandom});
      mac_pool[i][lmft_pkg::GROUP_BIT] = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_links();
    test_fill_table();
    test_routing();
    test_unlink();

    test_random_traffic(102);
    send_idle_pct = 55;
    recv_idle_pct = 29;
    test_random_traffic(102);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(102);
    push <= 1'b0;

    // Drain, then give the block time to show any stray word
    while (fwd_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
